// ----- design/ritx_pkg.sv -----
// ----------------------------------------------------------------------------
// ritx_pkg: shared types and constants for the radix text converter
// Widths, character codes and helper functions used by the front, the
// alphabet store/checker and the back end.
// ----------------------------------------------------------------------------
package ritx_pkg;

  localparam int NUM_W          = 32;
  localparam int CHAR_W         = 8;
  localparam int WORD_W         = 64;
  localparam int WORD_COUNT     = 8;
  localparam int WORD_IDX_W     = 3;
  localparam int CFG_IDX_W      = 4;
  localparam int ALPHABET_SLOTS = 64;
  localparam int POS_W          = 6;
  localparam int DIGIT_W        = 6;
  localparam int SEEN_W         = 64;
  localparam int RADIX_W        = 7;
  localparam int MAX_DIGITS     = 32;
  localparam int DSTORE_IDX_W   = 5;
  localparam int CNT_W          = 6;
  localparam int BITS_PER_CYCLE = 8;
  localparam int DIV_STEPS      = NUM_W / BITS_PER_CYCLE;
  localparam int DIV_STEP_W     = 2;
  localparam int QDEPTH         = 2;
  localparam int QPTR_W         = 1;
  localparam int QCNT_W         = 2;

  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

  localparam logic [RADIX_W-1:0] MIN_RADIX = 7'd2;

  // queued work item: sign and unsigned magnitude
  typedef struct packed {
    logic             neg;
    logic [NUM_W-1:0] mag;
  } item_t;

  // alphabet status seen by the back end
  typedef struct packed {
    logic               busy;
    logic               ok;
    logic [RADIX_W-1:0] radix;
  } alpha_stat_t;

  function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ) ||
           (c >= CH_LA && c <= CH_LZ);
  endfunction

  // dense code of an alphanumeric byte (garbage for others)
  function automatic logic [DIGIT_W-1:0] alnum_code(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    if (c <= CH_9) begin
      d = c - CH_0;
    end else if (c <= CH_UZ) begin
      d = c - CH_UA + 8'd10;
    end else begin
      d = c - CH_LA + 8'd36;
    end
    return d[DIGIT_W-1:0];
  endfunction

  function automatic logic [CHAR_W-1:0] pick_byte(input logic [WORD_W-1:0] w,
                                                   input logic [WORD_IDX_W-1:0] sel);
    return w[{sel, 3'b000} +: CHAR_W];
  endfunction

endpackage

// ----- design/ritx_ram.sv -----
// ----------------------------------------------------------------------------
// ritx_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ritx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/ritx_front.sv -----
// ----------------------------------------------------------------------------
// ritx_front: input side
// Takes numbers, splits them into sign and magnitude and queues them.
// ----------------------------------------------------------------------------
module ritx_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic signed [ritx_pkg::NUM_W-1:0] number,
  output logic                         full,
  input  logic                         pop,
  output ritx_pkg::item_t              item,
  output logic                         empty
);

  import ritx_pkg::*;

  item_t              ent_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  cnt_r;
  logic [NUM_W-1:0]   raw;
  item_t              cls;
  logic               do_push, do_pop;

  // magnitude via unsigned negate: most negative value stays exact
  assign raw     = number;
  assign cls.neg = raw[NUM_W-1];
  assign cls.mag = cls.neg ? (NUM_W'(0) - raw) : raw;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign item    = ent_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- design/ritx_alpha.sv -----
// ----------------------------------------------------------------------------
// ritx_alpha: alphabet store and checker
// Holds the eight alphabet words in a RAM, rescans them after each write to a
// word (length, alphanumeric test, duplicates) and serves digit characters.
// ----------------------------------------------------------------------------
module ritx_alpha (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ritx_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ritx_pkg::WORD_W-1:0]       cfg_data,
  input  logic [ritx_pkg::DIGIT_W-1:0]      rd_digit,
  output ritx_pkg::alpha_stat_t             stat,
  output logic [ritx_pkg::CHAR_W-1:0]       rd_char
);

  import ritx_pkg::*;

  localparam logic [1:0] CK_IDLE = 2'd0;
  localparam logic [1:0] CK_WAIT = 2'd1;
  localparam logic [1:0] CK_SCAN = 2'd2;

  logic                  wr_ok;
  logic [WORD_IDX_W-1:0] rd_addr;
  logic [WORD_W-1:0]     rdata, word_q;
  logic [WORD_COUNT-1:0] vld_r;
  logic                  rvld_r;
  logic [WORD_IDX_W-1:0] rsel_r;

  logic [1:0]            ck_st_r, ck_st_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [RADIX_W-1:0]    len_r, len_nxt, len_inc;
  logic                  good_r, good_nxt;
  logic [SEEN_W-1:0]     seen_r, seen_nxt;
  logic [RADIX_W-1:0]    radix_r, radix_nxt;
  logic                  ok_r, ok_nxt;
  logic [CHAR_W-1:0]     ck_byte;
  logic [DIGIT_W-1:0]    ck_code;
  logic                  ck_bad;

  assign wr_ok   = cfg_we && (cfg_index < CFG_IDX_W'(WORD_COUNT));
  assign rd_addr = (ck_st_r != CK_IDLE) ? pos_r[POS_W-1 -: WORD_IDX_W]
                                        : rd_digit[DIGIT_W-1 -: WORD_IDX_W];

  ritx_ram #(.WIDTH(WORD_W), .DEPTH(WORD_COUNT)) u_ram (
    .clk   (clk),
    .we    (wr_ok),
    .waddr (cfg_index[WORD_IDX_W-1:0]),
    .wdata (cfg_data),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // never-written words read as zero
  assign word_q  = rvld_r ? rdata : '0;
  assign rd_char = pick_byte(word_q, rsel_r);

  assign ck_byte = pick_byte(word_q, pos_r[WORD_IDX_W-1:0]);
  assign ck_code = alnum_code(ck_byte);
  assign ck_bad  = !is_alnum(ck_byte) || seen_r[ck_code];
  assign len_inc = len_r + 1'b1;

  always_comb begin
    ck_st_nxt = ck_st_r;
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    good_nxt  = good_r;
    seen_nxt  = seen_r;
    radix_nxt = radix_r;
    ok_nxt    = ok_r;
    case (ck_st_r)
      CK_WAIT: begin
        ck_st_nxt = CK_SCAN;
      end
      CK_SCAN: begin
        if (ck_byte == CH_NUL) begin
          radix_nxt = len_r;
          ok_nxt    = good_r && (len_r >= MIN_RADIX);
          ck_st_nxt = CK_IDLE;
        end else begin
          good_nxt          = good_r && !ck_bad;
          seen_nxt[ck_code] = 1'b1;
          len_nxt           = len_inc;
          if (pos_r == POS_W'(ALPHABET_SLOTS - 1)) begin
            radix_nxt = len_inc;
            ok_nxt    = good_nxt && (len_inc >= MIN_RADIX);
            ck_st_nxt = CK_IDLE;
          end else begin
            pos_nxt = pos_r + 1'b1;
            if (pos_r[WORD_IDX_W-1:0] == '1) begin
              ck_st_nxt = CK_WAIT;   // next word: wait for the registered RAM read
            end
          end
        end
      end
      default: begin
        ck_st_nxt = ck_st_r;
      end
    endcase
    if (wr_ok) begin
      ck_st_nxt = CK_WAIT;
      pos_nxt   = '0;
      len_nxt   = '0;
      good_nxt  = 1'b1;
      seen_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    rsel_r <= rd_digit[WORD_IDX_W-1:0];
    pos_r  <= pos_nxt;
    len_r  <= len_nxt;
    good_r <= good_nxt;
    seen_r <= seen_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      rvld_r  <= 1'b0;
      ck_st_r <= CK_IDLE;
      radix_r <= '0;
      ok_r    <= 1'b0;
    end else begin
      if (wr_ok) begin
        vld_r[cfg_index[WORD_IDX_W-1:0]] <= 1'b1;
      end
      rvld_r  <= vld_r[rd_addr];
      ck_st_r <= ck_st_nxt;
      radix_r <= radix_nxt;
      ok_r    <= ok_nxt;
    end
  end

  assign stat.busy  = (ck_st_r != CK_IDLE);
  assign stat.ok    = ok_r;
  assign stat.radix = radix_r;

endmodule

// ----- design/ritx_back.sv -----
// ----------------------------------------------------------------------------
// ritx_back: conversion back end
// Divides the magnitude by the radix eight quotient bits a cycle, stores
// the remainders, then emits sign and digits most significant first.
// ----------------------------------------------------------------------------
module ritx_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  ritx_pkg::item_t               q_item,
  output logic                          q_pop,
  input  ritx_pkg::alpha_stat_t         stat,
  output logic [ritx_pkg::DIGIT_W-1:0]  rd_digit,
  input  logic [ritx_pkg::CHAR_W-1:0]   rd_char,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [ritx_pkg::CHAR_W-1:0]   out_text_char,
  output logic                          out_last_char
);

  import ritx_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_LD   = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_WR   = 3'd4;

  logic [2:0]            st_r, st_nxt;
  logic [NUM_W-1:0]      q_r, q_nxt;
  logic [DIGIT_W-1:0]    rem_r, rem_nxt;
  logic [DIV_STEP_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt, cnt_m1, cnt_nxt_m1;
  logic                  neg_r, neg_nxt;
  logic                  sign_pend_r, sign_pend_nxt;
  logic                  dig_we;
  logic [NUM_W-1:0]      div_q;
  logic [DIGIT_W-1:0]    div_r;
  logic                  ov_r;
  logic [CHAR_W-1:0]     oc_r;
  logic                  ol_r;
  logic                  slot_free, push;
  logic [CHAR_W-1:0]     push_char;
  logic                  push_last;

  // eight restoring steps; remainder stays below radix (<= 64)
  always_comb begin : div_blk
    logic [RADIX_W-1:0] r7;
    logic [DIGIT_W-1:0] r6;
    logic [NUM_W-1:0]   qv;
    r6 = rem_r;
    qv = q_r;
    r7 = '0;
    for (int i = 0; i < BITS_PER_CYCLE; i++) begin
      r7 = {r6, qv[NUM_W-1]};
      qv = {qv[NUM_W-2:0], 1'b0};
      if (r7 >= stat.radix) begin
        r7    = r7 - stat.radix;
        qv[0] = 1'b1;
      end
      r6 = r7[DIGIT_W-1:0];
    end
    div_q = qv;
    div_r = r6;
  end

  // digit store: read address follows the next count, so once the last
  // write has landed the registered read data holds the top pending digit
  ritx_ram #(.WIDTH(DIGIT_W), .DEPTH(MAX_DIGITS)) u_dig (
    .clk   (clk),
    .we    (dig_we),
    .waddr (cnt_r[DSTORE_IDX_W-1:0]),
    .wdata (div_r),
    .raddr (cnt_nxt_m1[DSTORE_IDX_W-1:0]),
    .rdata (rd_digit)
  );

  assign cnt_m1     = cnt_r - 1'b1;
  assign cnt_nxt_m1 = cnt_nxt - 1'b1;
  assign slot_free  = !ov_r || out_pop;
  assign push_char  = sign_pend_r ? CH_MINUS : rd_char;
  assign push_last  = !sign_pend_r && (cnt_r == CNT_W'(1));

  always_comb begin
    st_nxt        = st_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    sign_pend_nxt = sign_pend_r;
    q_pop         = 1'b0;
    dig_we        = 1'b0;
    push          = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (!q_empty && !stat.busy) begin
          q_pop = 1'b1;
          if (stat.ok) begin        // bad alphabet: item dropped
            q_nxt    = q_item.mag;
            neg_nxt  = q_item.neg;
            rem_nxt  = '0;
            step_nxt = '0;
            cnt_nxt  = '0;
            st_nxt   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        q_nxt    = div_q;
        rem_nxt  = div_r;
        step_nxt = step_r + 1'b1;
        if (step_r == DIV_STEP_W'(DIV_STEPS - 1)) begin
          dig_we  = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          rem_nxt = '0;
          // zero input yields one zero digit here as well
          if (div_q == '0) begin
            sign_pend_nxt = neg_r;
            st_nxt        = ST_LD;
          end
        end
      end
      ST_LD: begin
        st_nxt = ST_RD;             // last digit write lands, fetch top digit
      end
      ST_RD: begin
        st_nxt = ST_WR;
      end
      ST_WR: begin
        if (slot_free) begin
          push = 1'b1;
          if (sign_pend_r) begin
            sign_pend_nxt = 1'b0;   // digit read already valid
          end else begin
            cnt_nxt = cnt_m1;
            st_nxt  = (cnt_r == CNT_W'(1)) ? ST_IDLE : ST_RD;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    q_r         <= q_nxt;
    rem_r       <= rem_nxt;
    step_r      <= step_nxt;
    neg_r       <= neg_nxt;
    sign_pend_r <= sign_pend_nxt;
    if (push) begin
      oc_r <= push_char;
      ol_r <= push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      if (push) begin
        ov_r <= 1'b1;
      end else if (out_pop) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_empty     = !ov_r;
  assign out_text_char = oc_r;
  assign out_last_char = ol_r;

`ifndef SYNTHESIS
  a_hold_while_checking: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE && stat.busy) |=> (st_r == ST_IDLE))
    else $error("back end started while alphabet check running");

  a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_DIGITS))
    else $error("digit count above store depth");

  a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DIV) |-> ({1'b0, rem_r} < stat.radix))
    else $error("partial remainder not below radix");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_last) |=> (st_r == ST_IDLE))
    else $error("last character transfer did not end the item");
`endif

endmodule

// ----- design/signed_integer_to_radix_text_top.sv -----
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text_top: signed integer to custom-radix text
// Converts signed 32-bit numbers to text over a configurable digit
// alphabet, one character per result transfer.
// ----------------------------------------------------------------------------
// Each number pushed on the in_ side comes out on the out_ side as a
// string of characters, most significant digit first, with a leading '-'
// for negative values; out_last_char marks the final character of a number.
// The radix is the length of the alphabet in cfg words 0..7 (low byte
// first, ended by the first zero byte, at most 64 characters). If the
// alphabet is shorter than two characters, holds a non-alphanumeric byte
// or holds a duplicate, numbers are taken and dropped with no output.
// Zero is emitted as the first alphabet character. After every write to an
// alphabet word the alphabet is rescanned (up to 8 word reads plus one byte
// a cycle); items queue but no new conversion starts during the scan. Per
// item: a start step, then for each digit the divider retires 8 quotient
// bits per cycle, then the top stored digit is fetched, and each character
// passes through the alphabet RAM read and the output register, the sign
// adding one more character.
// Front and back are split by a two-entry queue, so new numbers are taken
// while a conversion runs; the result side has a one-deep output register.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_text_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic signed [ritx_pkg::NUM_W-1:0]    in_number,
  // result channel
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic [ritx_pkg::CHAR_W-1:0]          out_text_char,
  output logic                                 out_last_char,
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [ritx_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ritx_pkg::WORD_W-1:0]          cfg_data
);

  import ritx_pkg::*;

  item_t              q_item;
  logic               q_empty;
  logic               q_pop;
  alpha_stat_t        stat;
  logic [DIGIT_W-1:0] rd_digit;
  logic [CHAR_W-1:0]  rd_char;

  // front: sign/magnitude split and the work queue
  ritx_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (in_push),
    .number (in_number),
    .full   (in_full),
    .pop    (q_pop),
    .item   (q_item),
    .empty  (q_empty)
  );

  // alphabet words, validity scan and digit character lookup
  ritx_alpha u_alpha (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rd_digit  (rd_digit),
    .stat      (stat),
    .rd_char   (rd_char)
  );

  // back: iterative division, digit store and character output
  ritx_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .stat          (stat),
    .rd_digit      (rd_digit),
    .rd_char       (rd_char),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_text_char (out_text_char),
    .out_last_char (out_last_char)
  );

endmodule

// ----- bench/ritx_text_checker.sv -----
// ----------------------------------------------------------------------------
// ritx_text_checker: scoreboard for the radix text converter
// Watches the config port and both queue channels, keeps its own copy of
// the alphabet, expands each accepted number into expected characters and
// compares every popped character against the oldest one waiting.
// ----------------------------------------------------------------------------
module ritx_text_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  input  logic                               in_full,
  input  logic signed [ritx_pkg::NUM_W-1:0]  in_number,
  input  logic                               out_empty,
  input  logic                               out_pop,
  input  logic [ritx_pkg::CHAR_W-1:0]        out_text_char,
  input  logic                               out_last_char,
  input  logic                               cfg_we,
  input  logic [ritx_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ritx_pkg::WORD_W-1:0]        cfg_data,
  output int                                 mismatch_count,
  output int                                 chars_pending
);
  import ritx_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] text_char;
    logic              last_char;
  } text_beat_t;

  logic [WORD_W-1:0] alphabet_words [WORD_COUNT];
  text_beat_t        expected_text [$];
  int                mismatches = 0;

  function automatic logic [CHAR_W-1:0] alphabet_char(input int pos);
    return alphabet_words[pos / 8][(pos % 8) * CHAR_W +: CHAR_W];
  endfunction

  task automatic expect_char(input logic [CHAR_W-1:0] ch, input logic last);
    text_beat_t beat;
    beat.text_char = ch;
    beat.last_char = last;
    expected_text.push_back(beat);
  endtask

  // Expand one number into the characters it should produce.
  task automatic predict_text(input logic [NUM_W-1:0] value);
    logic [CHAR_W-1:0]  ch;
    logic [255:0]       used;
    logic               usable;
    logic               ended;
    logic               negative;
    logic [NUM_W-1:0]   magnitude;
    logic [DIGIT_W-1:0] digits [MAX_DIGITS];
    int unsigned        radix;
    int                 ndigits;
    int                 p;

    used   = '0;
    usable = 1'b1;
    ended  = 1'b0;
    radix  = 0;
    for (p = 0; p < ALPHABET_SLOTS && !ended; p++) begin
      ch = alphabet_char(p);
      if (ch == CH_NUL) begin
        ended = 1'b1;
      end else begin
        if (!((ch >= CH_0 && ch <= CH_9) || (ch >= CH_UA && ch <= CH_UZ) ||
              (ch >= CH_LA && ch <= CH_LZ)) || used[ch]) begin
          usable = 1'b0;
        end
        used[ch] = 1'b1;
        radix++;
      end
    end
    if (radix < 2) usable = 1'b0;

    if (usable) begin
      negative  = value[NUM_W-1];
      // most negative value maps onto 0x80000000 as an unsigned magnitude
      magnitude = negative ? (~value + 1'b1) : value;
      if (magnitude == '0) begin
        expect_char(alphabet_char(0), 1'b1);
      end else begin
        ndigits = 0;
        while (magnitude != '0) begin
          digits[ndigits] = DIGIT_W'(magnitude % radix);
          magnitude       = magnitude / radix;
          ndigits++;
        end
        if (negative) expect_char(CH_MINUS, 1'b0);
        for (p = ndigits - 1; p >= 0; p--) begin
          expect_char(alphabet_char(digits[p]), p == 0);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    text_beat_t want;
    if (!rst_n) begin
      for (int w = 0; w < WORD_COUNT; w++) alphabet_words[w] = '0;
      expected_text.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_text.size() == 0) begin
          $display("%0t: unexpected char: expected none, actual 0x%02h last=%0b",
                   $time, out_text_char, out_last_char);
          mismatches++;
        end else begin
          want = expected_text.pop_front();
          if (out_text_char !== want.text_char) begin
            $display("%0t: text_char mismatch: expected 0x%02h, actual 0x%02h",
                     $time, want.text_char, out_text_char);
            mismatches++;
          end
          if (out_last_char !== want.last_char) begin
            $display("%0t: last_char mismatch: expected %0b, actual %0b",
                     $time, want.last_char, out_last_char);
            mismatches++;
          end
        end
      end
      // index 8 and above selects no register
      if (cfg_we && cfg_index < WORD_COUNT) begin
        alphabet_words[cfg_index[WORD_IDX_W-1:0]] = cfg_data;
      end
      if (in_push && !in_full) predict_text(in_number);
    end
    mismatch_count <= mismatches;
    chars_pending  <= expected_text.size();
  end

endmodule

// ----- bench/signed_integer_to_radix_text_top_tb.sv -----
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text_top_tb: testbench for the radix text converter
// Loads a series of digit alphabets (valid, invalid, shortest, longest,
// random) and pushes numbers through each one; a separate checker predicts
// every character and flags mismatches. Both channels idle at random.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_text_top_tb;
  import ritx_pkg::*;

  localparam int RESET_CYCLES   = 3;
  // margin for the slowest conversion plus the alphabet rescan
  localparam int SETTLE_CYCLES  = 400;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int RX_HOLD_CYCLES = 600;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 10;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_push;
  logic                     in_full;
  logic signed [NUM_W-1:0]  in_number;
  logic                     out_empty;
  logic                     out_pop;
  logic [CHAR_W-1:0]        out_text_char;
  logic                     out_last_char;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [WORD_W-1:0]        cfg_data;

  int mismatch_count;
  int chars_pending;
  int cycle_count;

  // shared between the stimulus and the result sink
  bit steady_run     = 1'b0;  // no idling on either side while set
  int stall_requests = 0;     // each bump asks the sink for one long hold-off

  logic [WORD_W-1:0] alphabet_image [WORD_COUNT];

  signed_integer_to_radix_text_top DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_number     (in_number),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_text_char (out_text_char),
    .out_last_char (out_last_char),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  ritx_text_checker u_text_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_number      (in_number),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_text_char  (out_text_char),
    .out_last_char  (out_last_char),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .chars_pending  (chars_pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Alphabet image helpers: build the eight words locally, then write them.
  // --------------------------------------------------------------------------
  task automatic put_char(input int pos, input logic [CHAR_W-1:0] ch);
    alphabet_image[pos / 8][(pos % 8) * CHAR_W +: CHAR_W] = ch;
  endtask

  task automatic set_alphabet_text(input string text);
    for (int w = 0; w < WORD_COUNT; w++) alphabet_image[w] = '0;
    for (int i = 0; i < text.len() && i < ALPHABET_SLOTS; i++) put_char(i, text[i]);
  endtask

  // any nonzero byte that is not a letter or a digit
  function automatic logic [CHAR_W-1:0] random_symbol();
    logic [CHAR_W-1:0] c;
    do begin
      c = CHAR_W'($urandom_range(1, 255));
    end while ((c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ) ||
               (c >= CH_LA && c <= CH_LZ));
    return c;
  endfunction

  // Shuffled alphanumeric alphabet of len chars with junk past the
  // terminator. spoil 1 plants a symbol, spoil 2 plants a repeated char.
  task automatic build_random_alphabet(input int len, input int spoil);
    logic [CHAR_W-1:0] pool [62];
    logic [CHAR_W-1:0] tmp;
    int                i;
    int                j;
    for (i = 0; i < 10; i++) pool[i] = CH_0 + CHAR_W'(i);
    for (i = 0; i < 26; i++) begin
      pool[10 + i] = CH_UA + CHAR_W'(i);
      pool[36 + i] = CH_LA + CHAR_W'(i);
    end
    for (i = 61; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = pool[i];
      pool[i] = pool[j];
      pool[j] = tmp;
    end
    for (i = 0; i < WORD_COUNT; i++) alphabet_image[i] = {$urandom, $urandom};
    for (i = 0; i < len; i++) put_char(i, pool[i]);
    if (len < ALPHABET_SLOTS) put_char(len, CH_NUL);
    if (spoil == 1) begin
      put_char($urandom_range(0, len - 1), random_symbol());
    end else if (spoil == 2) begin
      i = $urandom_range(1, len - 1);
      put_char(i, pool[$urandom_range(0, i - 1)]);
    end
  endtask

  // --------------------------------------------------------------------------
  // Config port. Leaves cfg_we high so back-to-back writes need one NBA per
  // edge; the caller drops it.
  // --------------------------------------------------------------------------
  task automatic write_register(input int index, input logic [WORD_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index[CFG_IDX_W-1:0];
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // all eight words, then optionally one write to an unused index (8..15)
  task automatic write_alphabet_words(input int stray_index);
    for (int w = 0; w < WORD_COUNT; w++) write_register(w, alphabet_image[w]);
    if (stray_index >= WORD_COUNT) write_register(stray_index, {$urandom, $urandom});
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Input side: one transfer per call, with an occasional random gap first.
  // --------------------------------------------------------------------------
  task automatic send_number(input logic [NUM_W-1:0] value);
    if (!steady_run && $urandom_range(0, 99) < 12) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_push   <= 1'b1;
    in_number <= value;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // Stop offering, wait for every expected character, then let the block
  // finish anything that produces no output (dropped items, rescan).
  task automatic wait_drained();
    in_push <= 1'b0;
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [NUM_W-1:0] random_number();
    logic [NUM_W-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0: v = 32'h0000_0000;
          1: v = 32'h0000_0001;
          2: v = 32'hFFFF_FFFF;
          3: v = 32'h7FFF_FFFF;
          4: v = 32'h8000_0000;
          default: v = 32'h8000_0001;
        endcase
      end
      1, 2: begin
        v = $urandom_range(0, 4000);
        if ($urandom_range(0, 1) != 0) v = -v;
      end
      3: v = 32'h8000_0000 + $urandom_range(0, 255);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: pops about 88% of cycles, always while steady_run is set,
  // and holds off for RX_HOLD_CYCLES whenever a stall is requested.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int served;
    served  = 0;
    out_pop = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_requests != served) begin
        served = stall_requests;
        out_pop <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end
      out_pop <= steady_run || ($urandom_range(0, 99) >= 12);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("signed_integer_to_radix_text_top_tb: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int len;
    int spoil;
    rst_n     = 1'b0;
    in_push   = 1'b0;
    in_number = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    for (int w = 0; w < WORD_COUNT; w++) alphabet_image[w] = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty alphabet out of reset: numbers are taken and dropped.
    send_number(32'd5);
    send_number(-32'sd5);
    wait_drained();

    // Decimal: zero, sign handling, both extremes.
    set_alphabet_text("0123456789");
    write_alphabet_words(-1);
    send_number(32'd0);
    send_number(32'd7);
    send_number(-32'sd1);
    send_number(32'd10);
    send_number(32'h7FFF_FFFF);
    send_number(32'h8000_0000);
    send_number(32'd1000000000);
    wait_drained();

    // Radix 2 is the minimum; the most negative number gives the longest text.
    set_alphabet_text("01");
    write_alphabet_words(-1);
    send_number(32'h8000_0000);
    send_number(32'h7FFF_FFFF);
    send_number(32'd0);
    send_number(32'd1);
    wait_drained();

    // Radix 62, the largest alphabet without repeats.
    set_alphabet_text({"0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ",
                       "abcdefghijklmnopqrstuvwxyz"});
    write_alphabet_words(-1);
    send_number(32'h8000_0000);
    send_number(32'd61);
    send_number(-32'sd3843);
    wait_drained();

    // Invalid alphabets: one char, a symbol, a repeat, all 64 slots used
    // (64 chars must repeat one). No output expected.
    set_alphabet_text("7");
    write_alphabet_words(-1);
    send_number(32'd12);
    wait_drained();
    set_alphabet_text("01+");
    write_alphabet_words(-1);
    send_number(32'd3);
    wait_drained();
    set_alphabet_text("0120");
    write_alphabet_words(-1);
    send_number(32'd3);
    wait_drained();
    build_random_alphabet(62, 0);
    put_char(62, alphabet_image[0][7:0]);
    put_char(63, alphabet_image[0][15:8]);
    write_alphabet_words(-1);
    send_number(32'd99);
    wait_drained();

    // Junk after the terminator is ignored, and a write to index 15 lands
    // nowhere, so "ab" stays a radix-2 alphabet.
    set_alphabet_text("ab");
    for (int p = 3; p < ALPHABET_SLOTS; p++) put_char(p, random_symbol());
    write_alphabet_words(15);
    send_number(-32'sd3);
    send_number(32'd0);
    wait_drained();

    // Random alphabets. Phase 1 is radix 62, phase 2 radix 2, phases 4 and
    // 7 are spoiled; phase 3 runs without idling, phase 5 holds the result
    // side off so the block backs up, phase 6 drains halfway through.
    for (int k = 0; k < RANDOM_PHASES; k++) begin
      case (k)
        1:       len = 62;
        2:       len = 2;
        default: len = $urandom_range(2, 62);
      endcase
      spoil = (k == 4 || k == 7) ? $urandom_range(1, 2) : 0;
      build_random_alphabet(len, spoil);
      write_alphabet_words($urandom_range(0, 1) != 0 ? $urandom_range(8, 15) : -1);
      if (k == 3) steady_run <= 1'b1;
      if (k == 5) stall_requests <= stall_requests + 1;
      for (int i = 0; i < (spoil != 0 ? 4 : PHASE_ITEMS); i++) begin
        if (k == 6 && i == PHASE_ITEMS / 2) wait_drained();
        send_number(random_number());
      end
      wait_drained();
      if (k == 3) steady_run <= 1'b0;
    end

    if (mismatch_count == 0 && chars_pending == 0) begin
      $display("signed_integer_to_radix_text_top_tb: PASS");
    end else begin
      $display("signed_integer_to_radix_text_top_tb: FAIL");
    end
    $finish;
  end

endmodule
